### design/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
// Holds the controller state enum and the controller-to-datapath command bundle.
// No dependencies.
package brf_pkg;

	localparam int BRF_DEPTH    = 256;
	localparam int BRF_CAP_BITS = 9;
	localparam int BRF_QW       = 7;
	localparam int BRF_PCT      = 100;
	localparam int BRF_SW       = 3;

	localparam logic BRF_CMD_PUSH = 1'b0;
	localparam logic BRF_CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} brf_state_t;

	typedef struct packed {
		logic              capture;
		logic              exec;
		logic              div_en;
		logic [BRF_SW-1:0] shift;
		logic              last;
	} brf_cmd_t;

endpackage

### design/brf_ctrl.sv
// Controller state machine for the byte ring FIFO.
// Sequences capture, store access, the seven divide steps and the result strobe.
// Depends on brf_pkg.
module brf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output brf_pkg::brf_cmd_t cmd
);
	import brf_pkg::*;

	brf_state_t        state_q, state_d;
	logic [BRF_SW-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.div_en  = 1'b0;
		cmd.shift   = step_q;
		cmd.last    = 1'b0;
		busy        = 1'b1;
		done        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				step_d   = BRF_SW'(BRF_QW - 1);
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				if (step_q == '0) begin
					cmd.last = 1'b1;
					state_d  = ST_DONE;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_DONE: begin
				// result shows this cycle; a new transfer may start at once
				busy = 1'b0;
				done = 1'b1;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### design/brf_dp.sv
// Datapath of the byte ring FIFO: capacity register, pointers, byte store,
// fill arithmetic and a restoring divider for the load percentage.
// Depends on brf_pkg; driven by brf_ctrl commands.
module brf_dp #(
	parameter int DEPTH = brf_pkg::BRF_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brf_pkg::brf_cmd_t              cmd,
	input  logic                           cfg_we,
	input  logic [brf_pkg::BRF_CAP_BITS-1:0] cfg_data,
	input  logic                           command,
	input  logic [7:0]                     data_in,
	output logic [7:0]                     read_data,
	output logic                           read_valid,
	output logic                           write_accepted,
	output logic [7:0]                     fill_level,
	output logic [6:0]                     load_percent
);
	import brf_pkg::*;

	localparam int REG_MAX = (1 << BRF_CAP_BITS) - 1;
	localparam int CAP_MAX = (DEPTH < REG_MAX) ? DEPTH : REG_MAX;
	localparam int CW      = $clog2(CAP_MAX + 1);
	localparam int MAW     = $clog2(CAP_MAX);
	localparam int NW      = $clog2(BRF_PCT * CAP_MAX);
	localparam int DW      = NW + BRF_QW;

	logic [BRF_CAP_BITS-1:0] cap_q;
	logic [CW-1:0]           cap_eff;
	logic [MAW-1:0]          wp_q, rp_q;
	logic                    cmd_q;
	logic [7:0]              din_q;
	logic [7:0]              mem [CAP_MAX];
	logic [7:0]              rd_q;
	logic                    rvalid_q, wacc_q;
	logic [CW-1:0]           fill_q;
	logic [NW-1:0]           rem_q;
	logic [BRF_QW-1:0]       quo_q;

	logic [CW-1:0]  fill_now, fill_new, wp_inc, rp_inc;
	logic           full, empty, do_push, do_pop;
	logic [DW-1:0]  trial, rem_ext, rem_sub;
	logic           take;
	logic [CW+7:0]  fill_wide;

	// clamp the register to the usable range
	always_comb begin
		if (cap_q < BRF_CAP_BITS'(2))
			cap_eff = CW'(2);
		else if (32'(cap_q) > 32'(CAP_MAX))
			cap_eff = CW'(CAP_MAX);
		else
			cap_eff = CW'(cap_q);
	end

	always_comb begin
		if (wp_q >= rp_q)
			fill_now = CW'(wp_q) - CW'(rp_q);
		else
			fill_now = cap_eff + CW'(wp_q) - CW'(rp_q);
		full     = (fill_now == cap_eff - 1'b1);
		empty    = (fill_now == '0);
		do_push  = (cmd_q == BRF_CMD_PUSH) && !full;
		do_pop   = (cmd_q == BRF_CMD_POP) && !empty;
		wp_inc   = CW'(wp_q) + 1'b1;
		rp_inc   = CW'(rp_q) + 1'b1;
		if (do_push)
			fill_new = fill_now + 1'b1;
		else if (do_pop)
			fill_new = fill_now - 1'b1;
		else
			fill_new = fill_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= BRF_CAP_BITS'(256);
			wp_q  <= '0;
			rp_q  <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
			wp_q  <= '0;
			rp_q  <= '0;
		end else if (cmd.exec) begin
			// wrap at the clamped capacity
			if (do_push)
				wp_q <= (wp_inc == cap_eff) ? '0 : wp_inc[MAW-1:0];
			if (do_pop)
				rp_q <= (rp_inc == cap_eff) ? '0 : rp_inc[MAW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			din_q <= data_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_push)
			mem[wp_q] <= din_q;
		if (cmd.exec && do_pop)
			rd_q <= mem[rp_q];
	end

	// restoring divide of 100 * fill by capacity, one quotient bit a step
	always_comb begin
		trial   = DW'(cap_eff) << cmd.shift;
		rem_ext = DW'(rem_q);
		take    = (rem_ext >= trial);
		rem_sub = rem_ext - trial;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rvalid_q <= do_pop;
			wacc_q   <= do_push;
			fill_q   <= fill_new;
			rem_q    <= NW'(NW'(fill_new) * NW'(BRF_PCT));
			quo_q    <= '0;
		end else if (cmd.div_en) begin
			if (take)
				rem_q <= rem_sub[NW-1:0];
			quo_q <= {quo_q[BRF_QW-2:0], take};
		end
	end

	assign fill_wide = (CW + 8)'(fill_q);

	always_ff @(posedge clk) begin
		if (cmd.last) begin
			read_data      <= rvalid_q ? rd_q : 8'd0;
			read_valid     <= rvalid_q;
			write_accepted <= wacc_q;
			fill_level     <= fill_wide[7:0];
			load_percent   <= {quo_q[BRF_QW-2:0], take};
		end
	end

endmodule

### design/byte_ring_fifo_with_load.sv
// Top level of the byte ring FIFO with fill level and load percentage.
// Instantiates brf_ctrl and brf_dp; depends on brf_pkg.
//
// Channel    Signals                                              Direction
// command    start, busy, command, data_in                        in
// result     done, read_data, read_valid, write_accepted,         out
//            fill_level, load_percent
// config     cfg_we, cfg_data (capacity)                          in
//
// A command transfers at an edge with start high and busy low. It passes
// through the store access, seven steps of the restoring divider and the
// result cycle, in which its result shows on the result ports with done high
// for one cycle; the next command may transfer at the edge that ends that
// cycle, so the block takes no new command while one is in flight. Reset
// empties the buffer and sets capacity to 256; a capacity write empties it
// too. The receiver cannot stall.
module byte_ring_fifo_with_load #(
	parameter int DEPTH = brf_pkg::BRF_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             command,
	input  logic [7:0]                       data_in,
	output logic                             done,
	output logic [7:0]                       read_data,
	output logic                             read_valid,
	output logic                             write_accepted,
	output logic [7:0]                       fill_level,
	output logic [6:0]                       load_percent,
	input  logic                             cfg_we,
	input  logic [brf_pkg::BRF_CAP_BITS-1:0] cfg_data
);
	import brf_pkg::*;

	brf_cmd_t cmd;

	brf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	brf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.command        (command),
		.data_in        (data_in),
		.read_data      (read_data),
		.read_valid     (read_valid),
		.write_accepted (write_accepted),
		.fill_level     (fill_level),
		.load_percent   (load_percent)
	);

endmodule

### verif/brf_outcome_checker.sv
// Checker for the byte ring FIFO: tracks command and capacity transfers, predicts each result
// from its own ring model and compares every done strobe against the oldest prediction.
// Depends on brf_pkg.
module brf_outcome_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             command,
	input  logic [7:0]                       data_in,
	input  logic                             done,
	input  logic [7:0]                       read_data,
	input  logic                             read_valid,
	input  logic                             write_accepted,
	input  logic [7:0]                       fill_level,
	input  logic [6:0]                       load_percent,
	input  logic                             cfg_we,
	input  logic [brf_pkg::BRF_CAP_BITS-1:0] cfg_data,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	typedef struct packed {
		logic [7:0] rdata;
		logic       rvalid;
		logic       wacc;
		logic [7:0] fill;
		logic [6:0] load;
	} fifo_outcome_t;

	fifo_outcome_t           outcome_q[$];
	logic [7:0]              ring [BRF_DEPTH];
	int                      wr_ptr;
	int                      rd_ptr;
	logic [BRF_CAP_BITS-1:0] cap_reg;

	// Out-of-range capacity saturates to the legal span.
	function automatic int slots_in_use();
		int c;
		c = int'(cap_reg);
		if (c < 2)
			c = 2;
		if (c > BRF_DEPTH)
			c = BRF_DEPTH;
		return c;
	endfunction

	function automatic int bytes_held(input int c);
		if (wr_ptr >= rd_ptr)
			return wr_ptr - rd_ptr;
		return c - (rd_ptr - wr_ptr);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic apply_command(input logic cmd, input logic [7:0] din,
			output fifo_outcome_t res);
		int c;
		int held;
		c = slots_in_use();
		held = bytes_held(c);
		res = '0;
		if (cmd == BRF_CMD_PUSH) begin
			// Keep one slot free; drop the byte when full.
			if (held < c - 1) begin
				ring[wr_ptr] = din;
				wr_ptr = (wr_ptr + 1 == c) ? 0 : wr_ptr + 1;
				res.wacc = 1'b1;
			end
		end else begin
			if (held > 0) begin
				res.rdata = ring[rd_ptr];
				res.rvalid = 1'b1;
				rd_ptr = (rd_ptr + 1 == c) ? 0 : rd_ptr + 1;
			end
		end
		held = bytes_held(c);
		res.fill = 8'(held);
		res.load = 7'((BRF_PCT * held) / c);
	endtask

	task automatic check_result();
		fifo_outcome_t want;
		if (outcome_q.size() == 0) begin
			report_mismatch("result with nothing outstanding", fill_level, 0);
		end else begin
			want = outcome_q.pop_front();
			if (read_data !== want.rdata)
				report_mismatch("read_data", read_data, want.rdata);
			if (read_valid !== want.rvalid)
				report_mismatch("read_valid", read_valid, want.rvalid);
			if (write_accepted !== want.wacc)
				report_mismatch("write_accepted", write_accepted, want.wacc);
			if (fill_level !== want.fill)
				report_mismatch("fill_level", fill_level, want.fill);
			if (load_percent !== want.load)
				report_mismatch("load_percent", load_percent, want.load);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fifo_outcome_t res;
		if (!arst_n) begin
			outcome_q.delete();
			wr_ptr = 0;
			rd_ptr = 0;
			cap_reg = BRF_CAP_BITS'(BRF_DEPTH);
			fail_count = 0;
			pending = 0;
			for (int i = 0; i < BRF_DEPTH; i++)
				ring[i] = 8'h00;
		end else begin
			if (done)
				check_result();
			// A capacity write empties the ring.
			if (cfg_we) begin
				cap_reg = cfg_data;
				wr_ptr = 0;
				rd_ptr = 0;
			end
			if (start && !busy) begin
				apply_command(command, data_in, res);
				outcome_q.push_back(res);
			end
			pending = outcome_q.size();
		end
	end

endmodule

### verif/byte_ring_fifo_with_load_test.sv
// Top of the byte ring FIFO testbench: clock, reset, command and capacity stimulus, verdict.
// Instantiates byte_ring_fifo_with_load and brf_outcome_checker; depends on brf_pkg.
module byte_ring_fifo_with_load_test;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 500;
	localparam int SETTLE_CYCLES  = 20;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    command;
	logic [7:0]              data_in;
	logic                    done;
	logic [7:0]              read_data;
	logic                    read_valid;
	logic                    write_accepted;
	logic [7:0]              fill_level;
	logic [6:0]              load_percent;
	logic                    cfg_we;
	logic [BRF_CAP_BITS-1:0] cfg_data;

	int fail_count;
	int pending;
	int idle_pct;
	int stall_cycles;

	byte_ring_fifo_with_load #(
		.DEPTH(BRF_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.data_in       (data_in),
		.done          (done),
		.read_data     (read_data),
		.read_valid    (read_valid),
		.write_accepted(write_accepted),
		.fill_level    (fill_level),
		.load_percent  (load_percent),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	brf_outcome_checker outcome_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.data_in       (data_in),
		.done          (done),
		.read_data     (read_data),
		.read_valid    (read_valid),
		.write_accepted(write_accepted),
		.fill_level    (fill_level),
		.load_percent  (load_percent),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic cmd, input logic [7:0] din);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		data_in <= din;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write capacity only once every outstanding result has come back.
	task automatic write_capacity(input logic [BRF_CAP_BITS-1:0] value);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One capacity setting followed by a fill-then-drain run; forced < 0 picks at random.
	task automatic random_chunk(input int forced, inout int sent);
		int extremes[7] = '{0, 1, 2, 3, 255, 256, 511};
		int v;
		int c;
		int sel;
		int n;
		int fill_n;
		int push_pct;
		logic cmd;
		if (forced >= 0) begin
			v = forced;
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 80)
				v = $urandom_range(2, 16);
			else if (sel < 92)
				v = $urandom_range(17, 64);
			else if (sel < 96)
				v = extremes[$urandom_range(0, 6)];
			else
				v = $urandom_range(0, 511);
		end
		write_capacity(BRF_CAP_BITS'(v));
		c = (v < 2) ? 2 : ((v > BRF_DEPTH) ? BRF_DEPTH : v);
		if (c > 64) begin
			// Push straight to full, then mix.
			fill_n = c + 8;
			n = fill_n + 30;
		end else begin
			n = $urandom_range(2 * c + 4, 3 * c + 20);
			fill_n = n / 2;
		end
		for (int i = 0; i < n; i++) begin
			if (i < fill_n)
				push_pct = (c > 64) ? 100 : 80;
			else
				push_pct = 25;
			if (c <= 64 && $urandom_range(0, 99) < 5)
				push_pct = 50;
			cmd = ($urandom_range(0, 99) < push_pct) ? BRF_CMD_PUSH : BRF_CMD_POP;
			send_item(cmd, 8'($urandom_range(0, 255)));
		end
		sent += n;
	endtask

	initial begin
		int sent;
		arst_n = 1'b0;
		start = 1'b0;
		command = BRF_CMD_PUSH;
		data_in = 8'h00;
		cfg_we = 1'b0;
		cfg_data = '0;
		idle_pct = 21;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset capacity: pop when empty, byte extremes, drain to empty.
		send_item(BRF_CMD_POP, 8'hFF);
		send_item(BRF_CMD_PUSH, 8'h00);
		send_item(BRF_CMD_PUSH, 8'hFF);
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_POP, 8'hFF);
		send_item(BRF_CMD_POP, 8'h00);
		// Smallest ring: one usable byte, so a second push is dropped and the pointers wrap.
		write_capacity(BRF_CAP_BITS'(2));
		send_item(BRF_CMD_PUSH, 8'hA5);
		send_item(BRF_CMD_PUSH, 8'h5A);
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_PUSH, 8'h3C);
		send_item(BRF_CMD_POP, 8'h00);
		// Capacity below the minimum saturates to two.
		write_capacity(BRF_CAP_BITS'(0));
		send_item(BRF_CMD_PUSH, 8'h81);
		send_item(BRF_CMD_PUSH, 8'h7E);
		// Write capacity while a byte is held: ring must come back empty.
		write_capacity(BRF_CAP_BITS'(3));
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_PUSH, 8'h01);
		send_item(BRF_CMD_PUSH, 8'h02);
		send_item(BRF_CMD_PUSH, 8'h03);
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_PUSH, 8'h04);
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_POP, 8'h00);
		send_item(BRF_CMD_POP, 8'h00);
		// Capacity above the store saturates to the store depth.
		write_capacity(BRF_CAP_BITS'(511));
		send_item(BRF_CMD_PUSH, 8'h55);
		send_item(BRF_CMD_POP, 8'h00);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 21 : ((phase == 1) ? 73 : 0);
			sent = 0;
			// Each phase starts by filling a large ring to full.
			if (phase == 0)
				random_chunk(BRF_DEPTH, sent);
			else if (phase == 1)
				random_chunk($urandom_range(BRF_DEPTH + 1, 511), sent);
			else
				random_chunk($urandom_range(65, BRF_DEPTH - 1), sent);
			while (sent < PHASE_ITEMS)
				random_chunk(-1, sent);
		end

		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
design/brf_pkg.sv
design/brf_ctrl.sv
design/brf_dp.sv
design/byte_ring_fifo_with_load.sv
verif/brf_outcome_checker.sv
verif/byte_ring_fifo_with_load_test.sv
